// ----- hdl/sst_pkg.sv -----
// Shared codes and state type for the swap slot table manager.
`timescale 1ns / 1ps
package sst_pkg;

  localparam logic [1:0] MODE_LOOKUP    = 2'd0;
  localparam logic [1:0] MODE_WRITE     = 2'd1;
  localparam logic [1:0] MODE_FREE_PROC = 2'd2;
  localparam logic [1:0] MODE_FREE_PAGE = 2'd3;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  localparam logic [1:0] CFG_FILE_COUNT = 2'd0;
  localparam logic [1:0] CFG_BLOCKS     = 2'd1;
  localparam logic [1:0] CFG_FRAMES     = 2'd2;
  localparam logic [1:0] CFG_ALLOC_MODE = 2'd3;

  localparam int CFG_W = 9;
  localparam int STATUS_W = 2;
  localparam int FILE_IDX_W = 2;
  localparam int BLOCK_IDX_W = 8;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIND,
    ST_PURGE,
    ST_OWNER,
    ST_COUNT,
    ST_DYN,
    ST_LEAD,
    ST_CHUNK,
    ST_DONE
  } st_e;

endpackage

// ----- hdl/sst_if.sv -----
// Request and response channel interfaces.
`timescale 1ns / 1ps
interface sst_req_if #(
  parameter int PID_BITS  = 16,
  parameter int PAGE_BITS = 20
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           mode;
  logic [PID_BITS-1:0]  process_id;
  logic [PAGE_BITS-1:0] page_number;

  modport source (output valid, mode, process_id, page_number, input ready);
  modport sink (input valid, mode, process_id, page_number, output ready);
endinterface

interface sst_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [1:0] file_index;
  logic [7:0] block_index;

  modport source (output valid, status, file_index, block_index, input ready);
  modport sink (input valid, status, file_index, block_index, output ready);
endinterface

// ----- hdl/sst_mem.sv -----
// Slot table memory, one write port and one registered read port.
`timescale 1ns / 1ps
module sst_mem #(
  parameter int AW = 10,
  parameter int DW = 37
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ----- hdl/sst_scan.sv -----
// Scan address generator with read tags aligned to memory read data.
`timescale 1ns / 1ps
module sst_scan #(
  parameter int FCNT_W = 3,
  parameter int FILE_W = 2,
  parameter int SLOT_W = 8,
  parameter int SUM_W  = 10
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic                     stop_i,
  input  logic [FCNT_W-1:0]        f_lo_i,
  input  logic [FCNT_W-1:0]        f_end_i,
  input  logic [SUM_W-1:0]         b_lo_i,
  input  logic [SUM_W-1:0]         b_step_i,
  input  logic [SUM_W-1:0]         b_end_i,
  output logic [FILE_W+SLOT_W-1:0] addr_o,
  output logic                     tag_v_o,
  output logic [FILE_W-1:0]        tag_f_o,
  output logic [SLOT_W-1:0]        tag_b_o,
  output logic                     tag_last_f_o,
  output logic                     tag_last_o
);
  logic              busy_q;
  logic [FCNT_W-1:0] f_q, f_end_q, f_nx;
  logic [SUM_W-1:0]  b_q, b_lo_q, b_step_q, b_end_q, b_nx;
  logic              last_f, last;

  assign b_nx   = b_q + b_step_q;
  assign f_nx   = f_q + FCNT_W'(1);
  assign last_f = b_nx >= b_end_q;
  assign last   = last_f && (f_nx >= f_end_q);
  assign addr_o = {f_q[FILE_W-1:0], b_q[SLOT_W-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      f_q          <= '0;
      f_end_q      <= '0;
      b_q          <= '0;
      b_lo_q       <= '0;
      b_step_q     <= '0;
      b_end_q      <= '0;
      tag_v_o      <= 1'b0;
      tag_f_o      <= '0;
      tag_b_o      <= '0;
      tag_last_f_o <= 1'b0;
      tag_last_o   <= 1'b0;
    end else if (start_i) begin
      busy_q   <= 1'b1;
      f_q      <= f_lo_i;
      f_end_q  <= f_end_i;
      b_q      <= b_lo_i;
      b_lo_q   <= b_lo_i;
      b_step_q <= b_step_i;
      b_end_q  <= b_end_i;
      tag_v_o  <= 1'b0;
    end else if (stop_i) begin
      busy_q  <= 1'b0;
      tag_v_o <= 1'b0;
    end else begin
      tag_v_o <= busy_q;
      if (busy_q) begin
        tag_f_o      <= f_q[FILE_W-1:0];
        tag_b_o      <= b_q[SLOT_W-1:0];
        tag_last_f_o <= last_f;
        tag_last_o   <= last;
        if (last) begin
          busy_q <= 1'b0;
        end
        if (last_f) begin
          b_q <= b_lo_q;
          f_q <= f_nx;
        end else begin
          b_q <= b_nx;
        end
      end
    end
  end
endmodule

// ----- hdl/swap_slot_table_manager.sv -----
// Top level: request sequencer, configuration registers and response register.
`timescale 1ns / 1ps
// Sequential block: one item at a time, each entry scan reads one slot per cycle
// from the single-port-read table memory. Lookup and frees scan every file, a
// lookup or page free ending early on a hit; a write takes up to three scans:
// owner search, free count per file, placement in one file (a lead scan and a
// chunk scan in static mode). A result that is not taken holds the sequencer,
// so the next item waits. After reset a clearing pass over every table entry
// runs before the first item is taken; configuration writes are taken meanwhile.
module swap_slot_table_manager
  import sst_pkg::*;
#(
  parameter int MAX_FILES          = 4,
  parameter int MAX_SLOTS_PER_FILE = 256,
  parameter int PID_BITS           = 16,
  parameter int PAGE_BITS          = 20
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  sst_req_if.sink          req,
  sst_rsp_if.source        rsp
);
  localparam int FILE_W = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
  localparam int SLOT_W = (MAX_SLOTS_PER_FILE > 1) ? $clog2(MAX_SLOTS_PER_FILE) : 1;
  localparam int FCNT_W = $clog2(MAX_FILES + 1);
  localparam int SCNT_W = $clog2(MAX_SLOTS_PER_FILE + 1);
  localparam int SUM_W  = ((SCNT_W > CFG_W) ? SCNT_W : CFG_W) + 1;
  localparam int AW     = FILE_W + SLOT_W;
  localparam int DW     = 1 + PID_BITS + PAGE_BITS;

  st_e state_q, state_d;

  logic [2:0]       file_cnt_q;
  logic [CFG_W-1:0] blocks_q, frames_q;
  logic             alloc_q;

  logic [1:0]           mode_q, mode_d;
  logic [PID_BITS-1:0]  pid_q, pid_d;
  logic [PAGE_BITS-1:0] page_q, page_d;
  logic [FILE_W-1:0]    file_q, file_d, best_q, best_d;
  logic [SCNT_W-1:0]    cnt_q, cnt_d, most_q, most_d, cnt_n, most_n;
  logic [FILE_W-1:0]    best_n;
  logic                 hit_q, hit_d, fh_q, fh_d, hit_n, fh_n;
  logic [SLOT_W-1:0]    hitb_q, hitb_d, fb_q, fb_d, hitb_n, fb_n;
  logic [1:0]           res_st_q, res_st_d;
  logic [1:0]           res_f_q, res_f_d;
  logic [7:0]           res_b_q, res_b_d;
  logic [AW-1:0]        clr_q;

  logic                 rsp_v_q, out_free, load;
  logic [1:0]           rsp_st_q, rsp_f_q;
  logic [7:0]           rsp_b_q;

  logic [FCNT_W-1:0] nf;
  logic [SCNT_W-1:0] nb;
  logic [CFG_W-1:0]  fr;
  logic              empty;
  st_e               place_st;

  logic              sc_start, sc_stop;
  logic [FCNT_W-1:0] sc_f_lo, sc_f_end;
  logic [SUM_W-1:0]  sc_b_lo, sc_b_step, sc_b_end, chunk_end;
  logic [AW-1:0]     rd_addr;
  logic              tv, tlf, tl;
  logic [FILE_W-1:0] tf;
  logic [SLOT_W-1:0] tb;

  logic          we, mem_we;
  logic [AW-1:0] waddr, mem_waddr;
  logic [DW-1:0] wdata, mem_wdata, rdata;

  logic                 rv, own, hold, pmatch, free;
  logic [PID_BITS-1:0]  rpid;
  logic [PAGE_BITS-1:0] rpage;

  assign nf = (32'(file_cnt_q) > 32'(MAX_FILES)) ? FCNT_W'(MAX_FILES)
                                                 : FCNT_W'(file_cnt_q);
  assign nb = (32'(blocks_q) > 32'(MAX_SLOTS_PER_FILE)) ? SCNT_W'(MAX_SLOTS_PER_FILE)
                                                         : SCNT_W'(blocks_q);
  assign fr = (frames_q == '0) ? CFG_W'(1) : frames_q;
  assign empty = (nf == '0) || (nb == '0);
  assign place_st = alloc_q ? ST_DYN : ST_LEAD;
  assign chunk_end = (SUM_W'(tb) + SUM_W'(fr) < SUM_W'(nb)) ? SUM_W'(tb) + SUM_W'(fr)
                                                             : SUM_W'(nb);

  assign rv     = rdata[DW-1];
  assign rpid   = rdata[PAGE_BITS +: PID_BITS];
  assign rpage  = rdata[PAGE_BITS-1:0];
  assign free   = !rv;
  assign own    = rv && (rpid == pid_q);
  assign pmatch = rv && (rpage == page_q);
  assign hold   = own && (rpage == page_q);

  assign cnt_n  = cnt_q + SCNT_W'(free);
  assign most_n = (tlf && cnt_n > most_q) ? cnt_n : most_q;
  assign best_n = (tlf && cnt_n > most_q) ? tf : best_q;
  assign hit_n  = hit_q || hold;
  assign hitb_n = hold ? tb : hitb_q;
  assign fh_n   = fh_q || free;
  assign fb_n   = (free && !fh_q) ? tb : fb_q;

  assign out_free  = !rsp_v_q || rsp.ready;
  assign load      = (state_q == ST_DONE) && out_free;
  assign req.ready = (state_q == ST_IDLE);
  assign rsp.valid       = rsp_v_q;
  assign rsp.status      = rsp_st_q;
  assign rsp.file_index  = rsp_f_q;
  assign rsp.block_index = rsp_b_q;

  assign mem_we    = (state_q == ST_CLEAR) || we;
  assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : waddr;
  assign mem_wdata = (state_q == ST_CLEAR) ? '0 : wdata;

  sst_mem #(.AW(AW), .DW(DW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  sst_scan #(.FCNT_W(FCNT_W), .FILE_W(FILE_W), .SLOT_W(SLOT_W), .SUM_W(SUM_W)) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (sc_start),
    .stop_i       (sc_stop),
    .f_lo_i       (sc_f_lo),
    .f_end_i      (sc_f_end),
    .b_lo_i       (sc_b_lo),
    .b_step_i     (sc_b_step),
    .b_end_i      (sc_b_end),
    .addr_o       (rd_addr),
    .tag_v_o      (tv),
    .tag_f_o      (tf),
    .tag_b_o      (tb),
    .tag_last_f_o (tlf),
    .tag_last_o   (tl)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == '1) state_d = ST_IDLE;
      ST_IDLE: begin
        if (req.valid) begin
          if (empty) begin
            state_d = ST_DONE;
          end else begin
            case (req.mode)
              MODE_WRITE:     state_d = ST_OWNER;
              MODE_FREE_PROC: state_d = ST_PURGE;
              default:        state_d = ST_FIND;
            endcase
          end
        end
      end
      ST_FIND:  if (tv && (hold || tl)) state_d = ST_DONE;
      ST_PURGE: if (tv && tl) state_d = ST_DONE;
      ST_OWNER: begin
        if (tv && own) state_d = place_st;
        else if (tv && tl) state_d = ST_COUNT;
      end
      ST_COUNT: if (tv && tl) state_d = (most_n == '0) ? ST_DONE : place_st;
      ST_DYN:   if (tv && tl) state_d = ST_DONE;
      ST_LEAD: begin
        if (tv && own) state_d = ST_CHUNK;
        else if (tv && tl) state_d = ST_DONE;
      end
      ST_CHUNK: if (tv && (pmatch || tl)) state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mode_d   = mode_q;
    pid_d    = pid_q;
    page_d   = page_q;
    file_d   = file_q;
    best_d   = best_q;
    cnt_d    = cnt_q;
    most_d   = most_q;
    hit_d    = hit_q;
    hitb_d   = hitb_q;
    fh_d     = fh_q;
    fb_d     = fb_q;
    res_st_d = res_st_q;
    res_f_d  = res_f_q;
    res_b_d  = res_b_q;
    sc_start  = 1'b0;
    sc_stop   = (state_d == ST_DONE);
    sc_f_lo   = '0;
    sc_f_end  = nf;
    sc_b_lo   = '0;
    sc_b_step = SUM_W'(1);
    sc_b_end  = SUM_W'(nb);
    we    = 1'b0;
    waddr = {tf, tb};
    wdata = '0;
    case (state_q)
      ST_IDLE: begin
        if (req.valid) begin
          mode_d   = req.mode;
          pid_d    = req.process_id;
          page_d   = req.page_number;
          hit_d    = 1'b0;
          fh_d     = 1'b0;
          cnt_d    = '0;
          most_d   = '0;
          best_d   = '0;
          res_st_d = STAT_OK;
          res_f_d  = '0;
          res_b_d  = '0;
          if (empty) begin
            if (req.mode == MODE_LOOKUP || req.mode == MODE_WRITE) res_st_d = STAT_MISS;
          end else begin
            sc_start = 1'b1;
          end
        end
      end
      ST_FIND: begin
        if (tv && hold) begin
          res_f_d = 2'(tf);
          res_b_d = 8'(tb);
          we = (mode_q == MODE_FREE_PAGE);
        end else if (tv && tl && mode_q == MODE_LOOKUP) begin
          res_st_d = STAT_MISS;
        end
      end
      ST_PURGE: we = tv && own;
      ST_OWNER, ST_COUNT: begin
        if (state_q == ST_COUNT && tv) begin
          cnt_d  = tlf ? '0 : cnt_n;
          most_d = most_n;
          best_d = best_n;
        end
        if (state_d == place_st) begin
          file_d    = (state_q == ST_OWNER) ? tf : best_n;
          sc_start  = 1'b1;
          sc_f_lo   = FCNT_W'(file_d);
          sc_f_end  = FCNT_W'(file_d) + FCNT_W'(1);
          sc_b_step = alloc_q ? SUM_W'(1) : SUM_W'(fr);
        end else if (state_d == ST_COUNT && state_q == ST_OWNER) begin
          sc_start = 1'b1;
        end else if (state_d == ST_DONE) begin
          res_st_d = STAT_MISS;
        end
      end
      ST_DYN, ST_LEAD, ST_CHUNK: begin
        if (tv) begin
          hit_d  = hit_n;
          hitb_d = hitb_n;
          fh_d   = fh_n;
          fb_d   = fb_n;
        end
        wdata = {1'b1, pid_q, page_q};
        if (state_q == ST_LEAD && tv && own) begin
          fh_d      = 1'b0;
          sc_start  = 1'b1;
          sc_f_lo   = FCNT_W'(file_q);
          sc_f_end  = FCNT_W'(file_q) + FCNT_W'(1);
          sc_b_lo   = SUM_W'(tb);
          sc_b_end  = chunk_end;
        end else if (state_q == ST_CHUNK && tv && pmatch) begin
          we      = 1'b1;
          waddr   = {file_q, tb};
          res_f_d = 2'(file_q);
          res_b_d = 8'(tb);
        end else if (tv && tl) begin
          if (state_q == ST_DYN && hit_n) begin
            we      = 1'b1;
            waddr   = {file_q, hitb_n};
            res_f_d = 2'(file_q);
            res_b_d = 8'(hitb_n);
          end else if (fh_n) begin
            we      = 1'b1;
            waddr   = {file_q, fb_n};
            res_f_d = 2'(file_q);
            res_b_d = 8'(fb_n);
          end else begin
            res_st_d = STAT_FULL;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_q      <= '0;
      file_cnt_q <= 3'd4;
      blocks_q   <= CFG_W'(256);
      frames_q   <= CFG_W'(16);
      alloc_q    <= 1'b1;
      rsp_v_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FILE_COUNT: file_cnt_q <= cfg_data_i[2:0];
          CFG_BLOCKS:     blocks_q   <= cfg_data_i;
          CFG_FRAMES:     frames_q   <= cfg_data_i;
          CFG_ALLOC_MODE: alloc_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (load) rsp_v_q <= 1'b1;
      else if (rsp.ready) rsp_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    pid_q    <= pid_d;
    page_q   <= page_d;
    file_q   <= file_d;
    best_q   <= best_d;
    cnt_q    <= cnt_d;
    most_q   <= most_d;
    hit_q    <= hit_d;
    hitb_q   <= hitb_d;
    fh_q     <= fh_d;
    fb_q     <= fb_d;
    res_st_q <= res_st_d;
    res_f_q  <= res_f_d;
    res_b_q  <= res_b_d;
    if (load) begin
      rsp_st_q <= res_st_q;
      rsp_f_q  <= res_f_q;
      rsp_b_q  <= res_b_q;
    end
  end

`ifndef NO_ASSERTIONS
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !req.ready) else $error("item taken during clear");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> !(rsp_v_q && !rsp.ready)) else $error("pending item overwritten");
  a_write_on_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && state_q != ST_CLEAR) |-> tv) else $error("table write without read data");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> state_q == ST_IDLE) else $error("sequencer stuck after result");
`endif
endmodule

// ----- bench/tb_swap_slot_table_manager.sv -----
// Testbench for the swap slot table manager: directed and random requests checked against a predictor.
`timescale 1ns / 1ps
module tb_swap_slot_table_manager;
  import sst_pkg::*;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] file_index;
    logic [7:0] block_index;
  } slot_reply_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = CFG_FILE_COUNT;
  logic [CFG_W-1:0] cfg_data_i = '0;

  sst_req_if req ();
  sst_rsp_if rsp ();

  swap_slot_table_manager u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .req(req.sink), .rsp(rsp.source)
  );

  always #1 clk_i = ~clk_i;

  // shadow table and registers
  bit        tbl_valid [4][256];
  bit [15:0] tbl_pid   [4][256];
  bit [19:0] tbl_page  [4][256];
  int unsigned sh_files, sh_blocks, sh_frames, sh_dynamic;

  slot_reply_t pending_replies[$];
  bit failed = 1'b0;
  bit idle_en = 1'b1;
  bit hold_rsp = 1'b0;

  function automatic int unsigned nfiles();
    return sh_files > 4 ? 4 : sh_files;
  endfunction

  function automatic int unsigned nslots();
    return sh_blocks > 256 ? 256 : sh_blocks;
  endfunction

  function automatic bit find_page(bit [15:0] pid, bit [19:0] pg, output int f, output int b);
    f = 0;
    b = 0;
    for (int x = 0; x < nfiles(); x++)
      for (int y = 0; y < nslots(); y++)
        if (tbl_valid[x][y] && tbl_pid[x][y] == pid && tbl_page[x][y] == pg) begin
          f = x;
          b = y;
          return 1'b1;
        end
    return 1'b0;
  endfunction

  function automatic slot_reply_t predict_slot(bit [1:0] mode, bit [15:0] pid, bit [19:0] pg);
    int f, b, best, most, n, fr, ns;
    bit got;
    bit [1:0] st;
    f = 0;
    b = 0;
    st = STAT_OK;
    ns = nslots();
    case (mode)
      MODE_LOOKUP: begin
        if (!find_page(pid, pg, f, b)) st = STAT_MISS;
      end
      MODE_WRITE: begin
        got = 1'b0;
        for (int x = 0; x < nfiles() && !got; x++)
          for (int y = 0; y < ns && !got; y++)
            if (tbl_valid[x][y] && tbl_pid[x][y] == pid) begin
              f = x;
              got = 1'b1;
            end
        if (!got) begin
          best = 0;
          most = 0;
          for (int x = 0; x < nfiles(); x++) begin
            n = 0;
            for (int y = 0; y < ns; y++) if (!tbl_valid[x][y]) n++;
            if (n > most) begin
              most = n;
              best = x;
            end
          end
          f = best;
          got = most != 0;
        end
        if (!got) st = STAT_MISS;
        else if (sh_dynamic != 0) begin
          got = 1'b0;
          for (int y = 0; y < ns; y++)
            if (tbl_valid[f][y] && tbl_pid[f][y] == pid && tbl_page[f][y] == pg) begin
              b = y;
              got = 1'b1;
            end
          for (int y = 0; y < ns && !got; y++)
            if (!tbl_valid[f][y]) begin
              b = y;
              got = 1'b1;
            end
          if (!got) st = STAT_FULL;
        end else begin
          fr = sh_frames == 0 ? 1 : sh_frames;
          st = STAT_FULL;
          got = 1'b0;
          for (int i = 0; i < ns && !got; i += fr)
            if (tbl_valid[f][i] && tbl_pid[f][i] == pid) begin
              got = 1'b1;
              for (int j = 0; j < fr && i + j < ns && st != STAT_OK; j++)
                if (tbl_valid[f][i+j] && tbl_page[f][i+j] == pg) begin
                  b = i + j;
                  st = STAT_OK;
                end
              for (int j = 0; j < fr && i + j < ns && st != STAT_OK; j++)
                if (!tbl_valid[f][i+j]) begin
                  b = i + j;
                  st = STAT_OK;
                end
            end
          if (!got)
            for (int i = 0; i < ns && st != STAT_OK; i += fr)
              if (!tbl_valid[f][i]) begin
                b = i;
                st = STAT_OK;
              end
        end
        if (st == STAT_OK) begin
          tbl_valid[f][b] = 1'b1;
          tbl_pid[f][b] = pid;
          tbl_page[f][b] = pg;
        end
      end
      MODE_FREE_PROC: begin
        for (int x = 0; x < nfiles(); x++)
          for (int y = 0; y < ns; y++)
            if (tbl_valid[x][y] && tbl_pid[x][y] == pid) begin
              tbl_valid[x][y] = 1'b0;
              tbl_pid[x][y] = '0;
              tbl_page[x][y] = '0;
            end
      end
      default: begin
        if (find_page(pid, pg, f, b)) begin
          tbl_valid[f][b] = 1'b0;
          tbl_pid[f][b] = '0;
          tbl_page[f][b] = '0;
        end
      end
    endcase
    if (st != STAT_OK) begin
      f = 0;
      b = 0;
    end
    return '{st, f[1:0], b[7:0]};
  endfunction

  task automatic send_request(bit [1:0] mode, bit [15:0] pid, bit [19:0] pg);
    while (idle_en && $urandom_range(99) < 35) @(negedge clk_i);
    req.valid = 1'b1;
    req.mode = mode;
    req.process_id = pid;
    req.page_number = pg;
    do @(posedge clk_i); while (!req.ready);
    pending_replies.push_back(predict_slot(mode, pid, pg));
    @(negedge clk_i);
    req.valid = 1'b0;
  endtask

  task automatic write_reg(bit [1:0] idx, bit [CFG_W-1:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_FILE_COUNT: sh_files = 32'(val[2:0]);
      CFG_BLOCKS: sh_blocks = 32'(val);
      CFG_FRAMES: sh_frames = 32'(val);
      default: sh_dynamic = 32'(val[0]);
    endcase
  endtask

  task automatic drain();
    while (pending_replies.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic set_config(int fc, int bpf, int fpp, int dyn);
    drain();
    write_reg(CFG_FILE_COUNT, CFG_W'(fc));
    write_reg(CFG_BLOCKS, CFG_W'(bpf));
    write_reg(CFG_FRAMES, CFG_W'(fpp));
    write_reg(CFG_ALLOC_MODE, CFG_W'(dyn));
  endtask

  // response side
  always @(negedge clk_i)
    rsp.ready <= !hold_rsp && !(idle_en && $urandom_range(99) < 35);

  always @(posedge clk_i) begin
    slot_reply_t exp_r;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected reply status=%0d", rsp.status);
        failed = 1'b1;
      end else begin
        exp_r = pending_replies.pop_front();
        if (rsp.status !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, rsp.status);
          failed = 1'b1;
        end
        if (rsp.file_index !== exp_r.file_index) begin
          $error("file_index exp %0d got %0d", exp_r.file_index, rsp.file_index);
          failed = 1'b1;
        end
        if (rsp.block_index !== exp_r.block_index) begin
          $error("block_index exp %0d got %0d", exp_r.block_index, rsp.block_index);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic test_directed();
    set_config(2, 4, 2, 1);
    send_request(MODE_LOOKUP, 16'hFFFF, 20'hFFFFF);
    send_request(MODE_FREE_PAGE, 16'h0, 20'h0);
    for (int i = 0; i < 9; i++) send_request(MODE_WRITE, 16'(i % 3), 20'hFFFFF - 20'(i));
    send_request(MODE_WRITE, 16'd0, 20'hFFFFF);
    send_request(MODE_LOOKUP, 16'd1, 20'hFFFFE);
    send_request(MODE_FREE_PAGE, 16'd1, 20'hFFFFE);
    send_request(MODE_LOOKUP, 16'd1, 20'hFFFFE);
    send_request(MODE_FREE_PROC, 16'd2, 20'hABCDE);
    send_request(MODE_WRITE, 16'hFFFF, 20'h0);
    set_config(1, 5, 2, 0);
    for (int i = 0; i < 7; i++) send_request(MODE_WRITE, 16'(i / 2), 20'h12 + 20'(i[0]));
    set_config(0, 0, 0, 0);
    send_request(MODE_WRITE, 16'd5, 20'd5);
    send_request(MODE_FREE_PROC, 16'd5, 20'd0);
  endtask

  task automatic random_phase(int count, int fc, int bpf, int fpp, int dyn);
    bit [1:0] m;
    set_config(fc, bpf, fpp, dyn);
    for (int i = 0; i < count; i++) begin
      m = $urandom_range(99) < 50 ? MODE_WRITE : 2'($urandom_range(3));
      if ($urandom_range(9) == 0)
        send_request(m, 16'($urandom), 20'($urandom));
      else
        send_request(m, 16'($urandom_range(3) | ($urandom_range(1) << 15)),
                     20'($urandom_range(5) | ($urandom_range(1) << 19)));
    end
  endtask

  task automatic test_backpressure();
    set_config(1, 8, 2, 1);
    fork
      begin
        hold_rsp = 1'b1;
        repeat (400) @(negedge clk_i);
        hold_rsp = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_request(MODE_LOOKUP, 16'(i), 20'(i));
    join
  endtask

  initial begin
    req.valid = 1'b0;
    req.mode = MODE_LOOKUP;
    req.process_id = '0;
    req.page_number = '0;
    rsp.ready = 1'b0;
    sh_files = 4;
    sh_blocks = 256;
    sh_frames = 16;
    sh_dynamic = 1;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    random_phase(40, 3, 8, 3, 1);
    random_phase(40, 2, 6, 4, 0);
    idle_en = 1'b0;
    random_phase(30, 7, 3, 1, 0);
    idle_en = 1'b1;
    random_phase(30, 1, 9, 9, 1);
    random_phase(8, 4, 256, 256, 1);
    random_phase(6, 4, 511, 16, 0);
    test_backpressure();
    drain();
    if (!failed) $display("tb_swap_slot_table_manager: PASS");
    else $display("tb_swap_slot_table_manager: FAIL");
    $finish;
  end

  initial begin
    #20000000;
    $display("tb_swap_slot_table_manager: FAIL");
    $finish;
  end
endmodule
